// File: src/assert_macros.svh
// Assertion macros shared by the page bitmap allocator RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pba_pkg.sv
// Package for the page bitmap allocator: sizes, codes, controller/datapath structs.
// No dependencies.
package pba_pkg;

    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 13;
    localparam int PAGE_SHIFT = 12;
    localparam int POOL_PAGES = 4096;
    localparam int WORD_BITS  = 32;   // bitmap row width; POOL_PAGES is a multiple of it
    localparam int ROWS       = POOL_PAGES / WORD_BITS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int IDX_W      = ROW_W + BIT_W;
    localparam int OFF_W      = ADDR_W - PAGE_SHIFT;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = ((COUNT_W + ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((ADDR_W + STATUS_W + 7) / 8) * 8;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 2'd0,
        STS_NO_PAGES = 2'd1,
        STS_BAD_FREE = 2'd2,
        STS_HALTED   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_A_READ,
        ST_A_LOAD,
        ST_A_FIND,
        ST_F_READ,
        ST_F_WRITE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic    capture;      // latch request fields
        logic    row_clr;
        logic    row_inc;
        logic    wr_zero;      // clear pass write
        logic    word_load;    // working word from read data
        logic    take;         // mark lowest free bit of working word
        logic    wr_word;      // write back working word
        logic    wr_free;      // clear one bit at the free row
        logic    set_halt;
        logic    status_load;
        t_status status_val;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic halted;
        logic kind;
        logic free_ok;
        logic word_full;
        logic last_row;
        logic last_take;
        logic out_free;
    } t_sts;

    // Position of the lowest zero bit; 0 when none (caller checks for full word).
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: src/pba_datapath.sv
// Datapath of the page bitmap allocator: bitmap memory, scan registers, result register.
// Depends on pba_pkg and assert_macros.svh; driven by pba_ctrl.
`include "assert_macros.svh"

module pba_datapath
    import pba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_valid,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_kind,
    input  logic [COUNT_W-1:0]   i_count,
    input  logic [ADDR_W-1:0]    i_free_addr,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    // bitmap, one row of WORD_BITS page flags per entry
    logic [WORD_BITS-1:0] r_mem [ROWS];
    logic [WORD_BITS-1:0] r_rd;

    logic [ADDR_W-1:0]    r_base;
    logic                 r_kind;
    logic [COUNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]    r_addr;
    logic [ROW_W-1:0]     r_row;
    logic [WORD_BITS-1:0] r_word;
    logic [COUNT_W-1:0]   r_taken;
    logic [IDX_W-1:0]     r_first;
    t_status              r_status;
    logic                 r_halted;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic [ADDR_W-1:0]    w_pool_base;
    logic [ADDR_W-1:0]    w_diff;
    logic [OFF_W-1:0]     w_off;
    logic                 w_free_ok;
    logic [ROW_W-1:0]     w_free_row;
    logic [BIT_W-1:0]     w_free_bit;
    logic [ROW_W-1:0]     w_rd_addr;
    logic [BIT_W-1:0]     w_pos;
    logic [WORD_BITS-1:0] w_mask;
    logic [COUNT_W-1:0]   w_count_eff;
    logic                 w_we;
    logic [ROW_W-1:0]     w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [ADDR_W-1:0]    w_out_addr;

    assign w_pool_base = {r_base[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
    assign w_diff      = r_addr - w_pool_base;
    assign w_off       = w_diff[ADDR_W-1:PAGE_SHIFT];
    assign w_free_ok   = (r_addr >= w_pool_base) && (w_off < OFF_W'(POOL_PAGES));
    assign w_free_row  = w_off[IDX_W-1:BIT_W];
    assign w_free_bit  = w_off[BIT_W-1:0];
    assign w_rd_addr   = (r_kind == KIND_FREE) ? w_free_row : r_row;

    assign w_pos       = first_zero(r_word);
    assign w_mask      = WORD_BITS'(1) << w_pos;
    assign w_count_eff = (r_count == '0) ? COUNT_W'(1) : r_count;

    always_comb begin
        w_we    = i_cmd.wr_zero | i_cmd.wr_word | i_cmd.wr_free;
        w_waddr = i_cmd.wr_free ? w_free_row : r_row;
        if (i_cmd.wr_free) begin
            w_wdata = r_rd & ~(WORD_BITS'(1) << w_free_bit);
        end else if (i_cmd.wr_word) begin
            w_wdata = r_word | (i_cmd.take ? w_mask : '0);
        end else begin
            w_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // request fields and scan payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_count <= i_count;
            r_addr  <= i_free_addr;
        end
        if (i_cmd.word_load) begin
            r_word <= r_rd;
        end else if (i_cmd.take) begin
            r_word <= r_word | w_mask;
        end
        if (i_cmd.capture) begin
            r_taken <= '0;
        end else if (i_cmd.take) begin
            r_taken <= r_taken + COUNT_W'(1);
        end
        if (i_cmd.take && (r_taken == '0)) begin
            r_first <= {r_row, w_pos};
        end
        if (i_cmd.status_load) begin
            r_status <= i_cmd.status_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_row    <= '0;
            r_halted <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.row_clr) begin
                r_row <= '0;
            end else if (i_cmd.row_inc) begin
                r_row <= r_row + ROW_W'(1);
            end
            if (i_cmd.set_halt) begin
                r_halted <= 1'b1;
            end
        end
    end

    // result register
    assign w_out_addr = ((r_status == STS_OK) && (r_kind == KIND_ALLOC))
                      ? w_pool_base + (ADDR_W'(r_first) << PAGE_SHIFT) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= M_TDATA_W'({r_status, w_out_addr});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign o_sts.halted    = r_halted;
    assign o_sts.kind      = r_kind;
    assign o_sts.free_ok   = w_free_ok;
    assign o_sts.word_full = &r_word;
    assign o_sts.last_row  = (r_row == ROW_W'(ROWS - 1));
    assign o_sts.last_take = ((r_taken + COUNT_W'(1)) == w_count_eff);
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    `ASSERT_NEXT(a_halt_sticky, r_halted, r_halted, "halted flag dropped without reset")
    `ASSERT_IMPL(a_no_overrun, i_cmd.out_load, !r_out_valid || i_m_tready, "result overwritten")
    `ASSERT_IMPL(a_take_has_room, i_cmd.take, !(&r_word), "page taken from a full row")

endmodule

// File: src/pba_ctrl.sv
// Controller of the page bitmap allocator: clear pass, request decode, scan sequencing.
// Depends on pba_pkg and assert_macros.svh; commands pba_datapath.
`include "assert_macros.svh"

module pba_ctrl
    import pba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.wr_zero = 1'b1;
                o_cmd.row_inc = 1'b1;
                if (i_sts.last_row) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.row_clr = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.halted) begin
                    o_cmd.status_load = 1'b1;
                    o_cmd.status_val  = STS_HALTED;
                    n_state           = ST_RESULT;
                end else if (i_sts.kind == KIND_ALLOC) begin
                    n_state = ST_A_READ;
                end else if (i_sts.free_ok) begin
                    n_state = ST_F_READ;
                end else begin
                    o_cmd.status_load = 1'b1;
                    o_cmd.status_val  = STS_BAD_FREE;
                    n_state           = ST_RESULT;
                end
            end
            ST_A_READ: begin
                n_state = ST_A_LOAD;
            end
            ST_A_LOAD: begin
                o_cmd.word_load = 1'b1;
                n_state         = ST_A_FIND;
            end
            ST_A_FIND: begin
                if (i_sts.word_full) begin
                    o_cmd.wr_word = 1'b1;
                    if (i_sts.last_row) begin
                        o_cmd.set_halt    = 1'b1;
                        o_cmd.status_load = 1'b1;
                        o_cmd.status_val  = STS_NO_PAGES;
                        n_state           = ST_RESULT;
                    end else begin
                        o_cmd.row_inc = 1'b1;
                        n_state       = ST_A_READ;
                    end
                end else begin
                    o_cmd.take = 1'b1;
                    if (i_sts.last_take) begin
                        o_cmd.wr_word     = 1'b1;
                        o_cmd.status_load = 1'b1;
                        o_cmd.status_val  = STS_OK;
                        n_state           = ST_RESULT;
                    end
                end
            end
            ST_F_READ: begin
                n_state = ST_F_WRITE;
            end
            ST_F_WRITE: begin
                o_cmd.wr_free     = 1'b1;
                o_cmd.status_load = 1'b1;
                o_cmd.status_val  = STS_OK;
                n_state           = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_free_in_pool, r_state == ST_F_WRITE, (i_sts.kind == KIND_FREE) && i_sts.free_ok, "free write outside pool")
    `ASSERT_NEXT(a_halt_reports, o_cmd.set_halt, r_state == ST_RESULT, "halt without result")

endmodule

// File: src/page_bitmap_allocator.sv
// Page bitmap allocator: after reset a clearing pass zeroes every row, no request taken.
// Allocate of N pages: one page per cycle while the row read has a free bit; each full
// row is read in turn from the single read port of the 128 x 32 bitmap. Free: row read,
// one bit cleared. One request at a time; a result waits in the output register.
// Reset (i_rst_n, synchronous, active low) clears base, halted flag and all page flags.
// Depends on pba_pkg, pba_ctrl, pba_datapath.

module page_bitmap_allocator
    import pba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: pool base address, low twelve bits ignored
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    // request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // page_count[12:0], free_address[44:13]
    input  logic                 i_s_axis_tuser,  // kind: 0 allocate, 1 free
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata   // page_address[31:0], status[33:32]
);

    t_cmd w_cmd;
    t_sts w_sts;

    // user changes base register only while idle, not enforced; writes always taken
    assign o_cfg_ready = 1'b1;

    pba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pba_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (i_s_axis_tuser),
        .i_count     (i_s_axis_tdata[COUNT_W-1:0]),
        .i_free_addr (i_s_axis_tdata[COUNT_W+ADDR_W-1:COUNT_W]),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata)
    );

endmodule

// File: verif/page_bitmap_allocator_checker.sv
`timescale 1ns / 100ps
// Scoreboard for page_bitmap_allocator: snoops the config, request and result channels,
// keeps its own page map and halt flag, and compares every result. Depends on pba_pkg.

module page_bitmap_allocator_checker
    import pba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic [S_TDATA_W-1:0] i_req_data,   // page_count[12:0], free_address[44:13]
    input  logic                 i_req_kind,   // kind: 0 allocate, 1 free
    input  logic                 i_grant_valid,
    input  logic                 i_grant_ready,
    input  logic [M_TDATA_W-1:0] i_grant_data, // page_address[31:0], status[33:32]
    output int                   o_fail_count,
    output int                   o_grants_owed
);

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        t_status           status;
    } t_grant;

    bit                page_taken [POOL_PAGES];
    bit                halted;
    logic [ADDR_W-1:0] pool_base;
    t_grant            grants_due [$];

    // Applies one request to the page map and returns the grant it should produce.
    function automatic t_grant grant_for(input logic kind, input logic [COUNT_W-1:0] pages,
                                         input logic [ADDR_W-1:0] addr);
        t_grant            g;
        int                need;
        int                taken;
        int                first;
        logic [ADDR_W-1:0] off;
        g.page_address = '0;
        g.status       = STS_OK;
        if (halted) begin
            g.status = STS_HALTED;
        end else if (kind == KIND_ALLOC) begin
            need  = (pages == 0) ? 1 : int'(pages);
            taken = 0;
            first = 0;
            for (int i = 0; i < POOL_PAGES && taken < need; i++) begin
                if (!page_taken[i]) begin
                    page_taken[i] = 1'b1;
                    if (taken == 0) begin
                        first = i;
                    end
                    taken++;
                end
            end
            // pages taken before running dry stay marked
            if (taken < need) begin
                halted   = 1'b1;
                g.status = STS_NO_PAGES;
            end else begin
                g.page_address = pool_base + (ADDR_W'(first) << PAGE_SHIFT);
            end
        end else if (addr < pool_base) begin
            g.status = STS_BAD_FREE;
        end else begin
            off = (addr - pool_base) >> PAGE_SHIFT;
            if (off >= POOL_PAGES) begin
                g.status = STS_BAD_FREE;
            end else begin
                page_taken[off] = 1'b0;
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin : watch
        t_grant got;
        t_grant want;
        if (!i_rst_n) begin
            foreach (page_taken[i]) begin
                page_taken[i] = 1'b0;
            end
            halted       = 1'b0;
            pool_base    = '0;
            o_fail_count = 0;
            grants_due.delete();
        end else begin
            // results first: a grant never leaves in the cycle its request enters
            if (i_grant_valid && i_grant_ready) begin
                got.page_address = i_grant_data[ADDR_W-1:0];
                got.status       = t_status'(i_grant_data[ADDR_W +: STATUS_W]);
                if (grants_due.size() == 0) begin
                    $display("%0t: unexpected result: page_address %h status %0d",
                             $time, got.page_address, got.status);
                    o_fail_count++;
                end else begin
                    want = grants_due.pop_front();
                    if (got.page_address !== want.page_address) begin
                        $display("%0t: page_address mismatch: expected %h actual %h",
                                 $time, want.page_address, got.page_address);
                        o_fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, got.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                pool_base = {i_cfg_data[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
            end
            if (i_req_valid && i_req_ready) begin
                grants_due.push_back(grant_for(i_req_kind, i_req_data[COUNT_W-1:0],
                                               i_req_data[COUNT_W +: ADDR_W]));
            end
        end
        o_grants_owed = grants_due.size();
    end

endmodule

// File: verif/page_bitmap_allocator_tb.sv
`timescale 1ns / 100ps
// Testbench top for page_bitmap_allocator: clock, reset, request stimulus, config writes
// and result back-pressure. Checking is done by page_bitmap_allocator_checker.

module page_bitmap_allocator_tb;
    import pba_pkg::*;

    localparam int IDLE_PCT   = 22;    // idle share on either side, in percent
    localparam int LONG_HOLD  = 400;   // cycles of the one long result stall
    localparam int HEADROOM   = 256;   // pages kept free so random traffic never runs dry
    localparam int SETTLE_CYC = 20;    // settle time after draining; nothing should trail

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [ADDR_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   grants_owed;

    // calm: neither side idles. hold_armed: the receiver starts its long stall.
    bit calm       = 1'b0;
    bit hold_armed = 1'b0;
    bit hold_used  = 1'b0;
    int hold_left  = 0;

    // Pages the stimulus believes are held. Allocation picks the lowest free pages here
    // as the block does, so this stays a superset of the block's used pages even when a
    // stray free lands on a held page; it only steers traffic, it checks nothing.
    bit                page_held [POOL_PAGES];
    int                held_count = 0;
    logic [ADDR_W-1:0] base_now   = '0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    page_bitmap_allocator u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    page_bitmap_allocator_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_req_valid   (s_tvalid),
        .i_req_ready   (s_tready),
        .i_req_data    (s_tdata),
        .i_req_kind    (s_tuser),
        .i_grant_valid (m_tvalid),
        .i_grant_ready (m_tready),
        .i_grant_data  (m_tdata),
        .o_fail_count  (fail_count),
        .o_grants_owed (grants_owed)
    );

    // Result side. Random stalls, none while calm, and one long stall on request from
    // the stimulus: the block ends up holding a finished grant plus the next request and
    // must push back on its input while the sender keeps offering.
    always @(posedge clk) begin
        if (hold_armed && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Hang guard, sized well past the slowest legal run including the clearing pass.
    initial begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Returns once every expected grant has come back.
    task automatic wait_drained();
        @(posedge clk);
        while (grants_owed != 0) @(posedge clk);
    endtask

    // Base may only change with the block idle: stop offering and let results drain.
    task automatic write_base(input logic [ADDR_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        base_now = {value[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
    endtask

    // Offers one request and returns at the edge that accepts it. tvalid is left high;
    // the next call either keeps it high or drops it for an idle gap.
    task automatic send_req(input logic kind, input logic [COUNT_W-1:0] pages,
                            input logic [ADDR_W-1:0] addr);
        int                want;
        logic [ADDR_W-1:0] off;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(40, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({addr, pages});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (kind == KIND_ALLOC) begin
            want = (pages == 0) ? 1 : int'(pages);
            for (int i = 0; i < POOL_PAGES && want > 0; i++) begin
                if (!page_held[i]) begin
                    page_held[i] = 1'b1;
                    held_count++;
                    want--;
                end
            end
        end else if (addr >= base_now) begin
            off = (addr - base_now) >> PAGE_SHIFT;
            if (off < POOL_PAGES && page_held[off]) begin
                page_held[off] = 1'b0;
                held_count--;
            end
        end
    endtask

    // One random request. Allocation odds fall as the pool fills, so occupancy settles
    // between a quarter and a half of the pool and scans cross many bitmap rows.
    // Most frees target held pages; some hit free pages, some are arbitrary addresses.
    task automatic random_req();
        int                 roll;
        int                 alloc_pct;
        int                 idx;
        logic [COUNT_W-1:0] pages;
        logic [ADDR_W-1:0]  addr;
        alloc_pct = (held_count < 1024) ? 45 : (held_count < 2048) ? 20 : 8;
        if ($urandom_range(99) < alloc_pct) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                pages = '0;
            end else if (roll < 75) begin
                pages = COUNT_W'($urandom_range(4, 1));
            end else if (roll < 97) begin
                pages = COUNT_W'($urandom_range(16, 5));
            end else begin
                pages = COUNT_W'($urandom_range(120, 17));
            end
            if (held_count + int'(pages) + 1 <= POOL_PAGES - HEADROOM) begin
                send_req(KIND_ALLOC, pages, ADDR_W'($urandom()));
                return;
            end
        end
        roll = $urandom_range(99);
        idx  = $urandom_range(POOL_PAGES - 1);
        if (roll >= 10 && held_count != 0) begin
            while (!page_held[idx]) idx = (idx + 1) % POOL_PAGES;
        end
        addr = base_now + (ADDR_W'(idx) << PAGE_SHIFT)
             + ADDR_W'($urandom_range((1 << PAGE_SHIFT) - 1));
        if (roll < 5) begin
            addr = ADDR_W'($urandom());
        end
        send_req(KIND_FREE, COUNT_W'($urandom()), addr);
    endtask

    initial begin : stimulus
        logic [ADDR_W-1:0] phase_base [5];
        int                phase_len  [5];
        phase_base = '{32'h0001_2ABC, 32'hFF00_0000, 32'hFFFF_FFFF, 32'h0, 32'h0};
        phase_len  = '{500, 450, 100, 400, 300};
        phase_base[3] = ADDR_W'($urandom());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: pool at address zero.
        write_base('0);
        send_req(KIND_ALLOC, '0, '0);                      // zero count takes one page
        send_req(KIND_ALLOC, 13'd1, '0);
        send_req(KIND_ALLOC, 13'd5, '0);                   // pages 2..6
        send_req(KIND_FREE, '0, 32'h0000_3FFF);            // page 3, last byte
        send_req(KIND_FREE, '0, 32'h0000_3000);            // page 3 again, already free
        send_req(KIND_ALLOC, 13'd2, '0);                   // pages 3 and 7, not contiguous
        send_req(KIND_ALLOC, 13'd1, '1);                   // address ignored on allocate
        send_req(KIND_FREE, '1, 32'h00FF_F000);            // last pool page; count ignored
        send_req(KIND_FREE, '0, 32'h0100_0000);            // one past the pool end
        send_req(KIND_FREE, '0, 32'hFFFF_FFFF);

        // Pool at the top of the address space; low base bits must be dropped.
        write_base(32'hFF00_0FFF);
        send_req(KIND_FREE, '0, 32'h0000_0000);            // below base
        send_req(KIND_FREE, '0, 32'hFEFF_FFFF);            // one byte below base
        send_req(KIND_FREE, '0, 32'hFF00_0000);            // page 0
        send_req(KIND_ALLOC, 13'd1, '0);                   // page 0 again
        send_req(KIND_FREE, '0, 32'hFFFF_FFFF);            // last pool page

        // Base in the last page: addresses wrap, only page 0 can ever be freed.
        write_base(32'hFFFF_FFFF);
        send_req(KIND_ALLOC, 13'd3, '0);
        send_req(KIND_FREE, '0, 32'hFFFF_F800);
        send_req(KIND_FREE, '0, 32'h0000_1000);            // wrapped page: below base

        // Random traffic, one base per phase.
        for (int p = 0; p < 5; p++) begin
            write_base(phase_base[p]);
            for (int n = 0; n < phase_len[p]; n++) begin
                calm <= (p == 0 && n >= 100 && n < 300);
                if (p == 0 && n == 350) begin
                    hold_armed <= 1'b1;
                end
                random_req();
            end
        end

        // Exhaustion: a count beyond the pool runs dry partway and halts the block;
        // everything after that is rejected.
        send_req(KIND_ALLOC, '1, '0);
        send_req(KIND_ALLOC, COUNT_W'(POOL_PAGES), '0);
        send_req(KIND_FREE, '0, base_now);
        send_req(KIND_ALLOC, 13'd1, '0);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        if (fail_count == 0 && grants_owed == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
